// ----- src/rwpr_pkg.sv -----
// Shared types, codes and constants of the ripple wave pixel renderer.
package rwpr_pkg;

   typedef struct packed {
      logic [1:0]         command;
      logic [4:0]         pixel_x;
      logic [3:0]         pixel_y;
      logic [15:0]        frame;
      logic [3:0]         slot;
      logic [4:0]         center_x;
      logic [3:0]         center_y;
      logic [15:0]        wave_freq;
      logic signed [15:0] wave_speed;
      logic [15:0]        wave_phase;
      logic [15:0]        wave_amplitude;
      logic [23:0]        color;
   } req_type;

   typedef struct packed {
      logic [9:0] led_index;
      logic       in_range;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rsp_type;

   localparam logic [1:0] CMD_SOURCE  = 2'd0;
   localparam logic [1:0] CMD_PALETTE = 2'd1;
   localparam logic [1:0] CMD_RENDER  = 2'd2;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 10;

   localparam logic [2:0] REG_PALETTE_SIZE   = 3'd0;
   localparam logic [2:0] REG_PANEL_ORDER    = 3'd1;
   localparam logic [2:0] REG_ROTATION_LEFT  = 3'd2;
   localparam logic [2:0] REG_ROTATION_RIGHT = 3'd3;
   localparam logic [2:0] REG_LED_COUNT      = 3'd4;

   localparam logic [1:0] ROT_NONE = 2'd0;
   localparam logic [1:0] ROT_90   = 2'd1;
   localparam logic [1:0] ROT_180  = 2'd2;
   localparam logic [1:0] ROT_270  = 2'd3;

   localparam logic [9:0] LED_COUNT_RESET = 10'd512;
   localparam logic [1:0] ROTATION_RESET  = ROT_90;

   // 0.05 in Q16
   localparam logic [11:0] TIME_STEP = 12'd3277;
   // 1024 / (2*pi) in Q24
   localparam logic [31:0] ANGLE_TO_INDEX = 32'd2734261102;

   localparam int DIST_BITS = 14;

   // Quarter-wave sine in Q14, u in 1/256 of a quarter turn.
   function automatic logic [13:0] quarter_sine(input logic [8:0] u);
      logic [63:0] uu;
      logic [63:0] sq;
      logic [63:0] p;
      logic [63:0] r;
      uu = 64'(u);
      sq = uu * uu;
      p  = 64'd5223 - ((sq * 64'd307) >> 16);
      p  = 64'd42334 - ((sq * p) >> 16);
      p  = 64'd102944 - ((sq * p) >> 16);
      r  = ((uu * p) >> 8) >> 2;
      return r[13:0];
   endfunction

endpackage

// ----- src/rwpr_ram.sv -----
// Generic RAM: one write port, two registered read ports.
module rwpr_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ----- src/ripple_wave_pixel_renderer.sv -----
// Ripple wave pixel renderer: source and palette loading, pipelined pixel rendering.
//
// Input transfers on req_* carry a command: load a ripple source, load a palette
// color, or render one pixel at a frame number. Only a render gives a result,
// one transfer on rsp_* with the chain LED index, its in_range flag and the color.
// Configuration registers are written over csr_* (csr_ready is always high); the
// user must write them only while idle, as the block does not enforce it. The
// renderer is one pipeline with a single advance enable. A render enters each
// cycle and one result leaves per cycle sustained while rsp_stall is low. The
// depth is set by the 14-bit square root (two bits per stage), the split 45x32
// angle scaling, the registered sum tree over the sources and one stage per
// quotient bit in the palette position divide. Source loads take effect at once;
// palette loads travel the pipeline and write the palette RAM where renders read
// it, so order holds. While rsp_stall holds a waiting result, the whole pipeline
// freezes and req_stall rises; nothing is dropped or repeated. Synchronous reset
// empties the pipeline, clears the sources and sets the registers to their
// defaults; the palette RAM is not cleared and must be loaded before use.
module ripple_wave_pixel_renderer #(
   parameter int SOURCES       = 4,
   parameter int PALETTE_DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  rwpr_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output rwpr_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [rwpr_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [rwpr_pkg::CSR_DATA_WIDTH-1:0]   csr_data
);

   localparam int LV   = $clog2(SOURCES);
   localparam int NP   = 1 << LV;
   localparam int SUMW = 32 + LV;
   localparam int PW   = 30 + LV;
   localparam int QB   = $clog2(PALETTE_DEPTH);
   localparam int NW   = PW + QB;
   localparam int PSW  = QB + 1;
   localparam int RW   = PW + 8;

   localparam int S_IN_IDX   = 1;
   localparam int S_SQ_FIRST = 2;
   localparam int S_SQ_LAST  = 8;
   localparam int S_MUL      = 9;
   localparam int S_ANG      = 10;
   localparam int S_PRD      = 11;
   localparam int S_IDX      = 12;
   localparam int S_SIN      = 13;
   localparam int S_AMP      = 14;
   localparam int S_SUM      = S_AMP + LV;
   localparam int S_POS      = S_SUM + 1;
   localparam int S_NUM      = S_POS + 1;
   localparam int S_R2       = S_NUM + QB + 1;
   localparam int S_ADR      = S_R2 + 9;
   localparam int NST        = S_ADR + 1;

   localparam logic signed [SUMW:0] OFFSET = (SUMW + 1)'(SOURCES) << 28;
   localparam logic [PW-1:0]        DEN    = PW'(SOURCES) << 29;
   localparam logic [13:0]          QS_TOP = rwpr_pkg::quarter_sine(9'd256);
   localparam logic [27:0]          TIME_STEP_W = 28'(rwpr_pkg::TIME_STEP);

   typedef struct packed {
      logic [10:0]        d2;
      logic [13:0]        root;
      logic [27:0]        sq;
      logic [15:0]        freq;
      logic signed [15:0] speed;
      logic [15:0]        phase;
      logic [15:0]        amp;
      logic signed [43:0] tq;
   } lane_type;

   typedef struct packed {
      logic        valid;
      logic        render;
      logic        palw;
      logic [3:0]  slot;
      logic [23:0] color;
      logic [9:0]  led;
      logic        inr;
   } ctl_type;

   // config
   logic [4:0] palette_size_ff;
   logic       panel_order_ff;
   logic [1:0] rot_left_ff;
   logic [1:0] rot_right_ff;
   logic [9:0] led_count_ff;

   // sources
   logic [4:0]         src_cx_ff   [SOURCES];
   logic [3:0]         src_cy_ff   [SOURCES];
   logic [15:0]        src_freq_ff [SOURCES];
   logic signed [15:0] src_speed_ff[SOURCES];
   logic [15:0]        src_phase_ff[SOURCES];
   logic [15:0]        src_amp_ff  [SOURCES];

   logic    adv;
   logic    acc;
   ctl_type ctl_in;
   ctl_type ctl_ff [1:NST];
   logic [9:0] led_in;

   logic [27:0] tf_ff;
   lane_type    front_ff [S_IN_IDX:S_SQ_LAST][SOURCES];

   logic [29:0]        mul_ff  [SOURCES];
   logic [15:0]        ph9_ff  [SOURCES];
   logic signed [43:0] tq9_ff  [SOURCES];
   logic [15:0]        amp9_ff [SOURCES];
   logic signed [44:0] ang_ff  [SOURCES];
   logic [15:0]        amp10_ff[SOURCES];
   logic signed [55:0] phi_ff  [SOURCES];
   logic [53:0]        plo_ff  [SOURCES];
   logic [15:0]        amp11_ff[SOURCES];
   logic [9:0]         idx_ff  [SOURCES];
   logic [15:0]        amp12_ff[SOURCES];
   logic signed [14:0] sin_ff  [SOURCES];
   logic [15:0]        amp13_ff[SOURCES];

   logic signed [SUMW-1:0] tree_ff [0:LV][NP];

   logic [PW-1:0]  pos_ff;
   logic [NW-1:0]  brem_ff [0:QB];
   logic [QB-1:0]  bq_ff   [0:QB];
   logic [RW-1:0]  wrem_ff [0:8];
   logic [7:0]     wq_ff   [0:8];
   logic [QB-1:0]  wbase_ff[0:8];
   logic [QB-1:0]  addr_a_ff;
   logic [QB-1:0]  addr_b_ff;
   logic [7:0]     wgt_a_ff;
   logic [7:0]     wgt_b_ff;

   logic [PSW-1:0] psz;
   logic [QB-1:0]  pm1;
   logic [13:0]    qs_table [256];

   logic              ram_we;
   logic [23:0]       ram_rd_a;
   logic [23:0]       ram_rd_b;

   logic              rsp_valid_ff;
   rwpr_pkg::rsp_type rsp_data_ff;

   function automatic logic [9:0] chain_index(input logic [4:0] x, input logic [3:0] y,
                                              input logic [1:0] rot, input logic order);
      logic [3:0] lx;
      logic [3:0] ly;
      logic [3:0] t;
      lx = x[3:0];
      ly = y;
      t  = 4'd0;
      case (rot)
         rwpr_pkg::ROT_90: begin
            t  = ly;
            ly = 4'd15 - lx;
            lx = t;
         end
         rwpr_pkg::ROT_180: begin
            lx = 4'd15 - lx;
            ly = 4'd15 - ly;
         end
         rwpr_pkg::ROT_270: begin
            t  = 4'd15 - ly;
            ly = lx;
            lx = t;
         end
         default: begin
            t = 4'd0;
         end
      endcase
      if (ly[0]) begin
         lx = 4'd15 - lx;
      end
      return {1'b0, x[4] ^ order, ly, lx};
   endfunction

   function automatic logic [7:0] blend(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] w);
      logic [16:0] pa;
      logic [16:0] pb;
      logic [8:0]  s;
      pa = 17'(a) * 17'(9'd256 - 9'(w));
      pb = 17'(b) * 17'(9'(w) + 9'd1);
      s  = 9'(pa >> 8) + 9'(pb >> 8);
      if (w == 8'd0) begin
         return a;
      end
      if (w == 8'd255) begin
         return b;
      end
      return s[7:0];
   endfunction

   for (genvar u = 0; u < 256; u++) begin : g_qs
      localparam logic [13:0] QS = rwpr_pkg::quarter_sine(9'(u));
      assign qs_table[u] = QS;
   end

   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;
   assign acc       = req_valid && adv;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign psz = (palette_size_ff > PALETTE_DEPTH) ? PSW'(PALETTE_DEPTH) : PSW'(palette_size_ff);
   assign pm1 = QB'(psz - PSW'(1));

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         palette_size_ff <= 5'd0;
         panel_order_ff  <= 1'b0;
         rot_left_ff     <= rwpr_pkg::ROTATION_RESET;
         rot_right_ff    <= rwpr_pkg::ROTATION_RESET;
         led_count_ff    <= rwpr_pkg::LED_COUNT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            rwpr_pkg::REG_PALETTE_SIZE:   palette_size_ff <= csr_data[4:0];
            rwpr_pkg::REG_PANEL_ORDER:    panel_order_ff  <= csr_data[0];
            rwpr_pkg::REG_ROTATION_LEFT:  rot_left_ff     <= csr_data[1:0];
            rwpr_pkg::REG_ROTATION_RIGHT: rot_right_ff    <= csr_data[1:0];
            rwpr_pkg::REG_LED_COUNT:      led_count_ff    <= csr_data[9:0];
            default: begin
            end
         endcase
      end
   end

   // source slots
   for (genvar i = 0; i < SOURCES; i++) begin : g_src
      always_ff @(posedge clock) begin
         if (reset) begin
            src_cx_ff[i]    <= '0;
            src_cy_ff[i]    <= '0;
            src_freq_ff[i]  <= '0;
            src_speed_ff[i] <= '0;
            src_phase_ff[i] <= '0;
            src_amp_ff[i]   <= '0;
         end else if (acc && req_data.command == rwpr_pkg::CMD_SOURCE
                      && req_data.slot == 4'(i)) begin
            src_cx_ff[i]    <= req_data.center_x;
            src_cy_ff[i]    <= req_data.center_y;
            src_freq_ff[i]  <= req_data.wave_freq;
            src_speed_ff[i] <= req_data.wave_speed;
            src_phase_ff[i] <= req_data.wave_phase;
            src_amp_ff[i]   <= req_data.wave_amplitude;
         end
      end
   end

   // control line
   always_comb begin
      led_in = chain_index(req_data.pixel_x, req_data.pixel_y,
                           req_data.pixel_x[4] ? rot_right_ff : rot_left_ff, panel_order_ff);
      ctl_in.render = req_data.command == rwpr_pkg::CMD_RENDER;
      ctl_in.palw   = req_data.command == rwpr_pkg::CMD_PALETTE;
      ctl_in.valid  = acc && (ctl_in.render || ctl_in.palw);
      ctl_in.slot   = req_data.slot;
      ctl_in.color  = req_data.color;
      ctl_in.led    = led_in;
      ctl_in.inr    = led_in < led_count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= NST; k++) begin
            ctl_ff[k].valid <= 1'b0;
         end
      end else if (adv) begin
         ctl_ff[1] <= ctl_in;
         for (int k = 2; k <= NST; k++) begin
            ctl_ff[k] <= ctl_ff[k-1];
         end
      end
   end

   // entry stage
   always_ff @(posedge clock) begin
      if (adv) begin
         tf_ff <= 28'(req_data.frame * TIME_STEP_W);
      end
   end

   for (genvar i = 0; i < SOURCES; i++) begin : g_entry
      logic signed [5:0] dx;
      logic signed [5:0] dy;
      lane_type          ln;
      always_comb begin
         dx       = $signed({1'b0, req_data.pixel_x}) - $signed({1'b0, src_cx_ff[i]});
         dy       = $signed({2'b0, req_data.pixel_y}) - $signed({2'b0, src_cy_ff[i]});
         ln.d2    = 11'(12'(dx * dx) + 12'(dy * dy));
         ln.root  = '0;
         ln.sq    = '0;
         ln.freq  = src_freq_ff[i];
         ln.speed = src_speed_ff[i];
         ln.phase = src_phase_ff[i];
         ln.amp   = src_amp_ff[i];
         ln.tq    = '0;
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            front_ff[S_IN_IDX][i] <= ln;
         end
      end
   end

   // square root, two result bits per stage; time term at the first stage
   for (genvar k = S_SQ_FIRST; k <= S_SQ_LAST; k++) begin : g_sq
      for (genvar i = 0; i < SOURCES; i++) begin : g_lane
         lane_type nx;
         always_comb begin
            logic [29:0]        v;
            logic [29:0]        t;
            logic signed [44:0] tqw;
            int                 b;
            nx  = front_ff[k-1][i];
            v   = 30'({nx.d2, 16'h0});
            tqw = $signed({1'b0, tf_ff}) * nx.speed;
            if (k == S_SQ_FIRST) begin
               nx.tq = tqw[43:0];
            end
            for (int s = 0; s < 2; s++) begin
               b = rwpr_pkg::DIST_BITS - 1 - 2 * (k - S_SQ_FIRST) - s;
               t = 30'(nx.sq) + (30'(nx.root) << (b + 1)) + (30'd1 << (2 * b));
               if (t <= v) begin
                  nx.root = nx.root | (14'd1 << b);
                  nx.sq   = t[27:0];
               end
            end
         end
         always_ff @(posedge clock) begin
            if (adv) begin
               front_ff[k][i] <= nx;
            end
         end
      end
   end

   // angle, table index, sine and amplitude per lane
   for (genvar i = 0; i < SOURCES; i++) begin : g_wave
      logic signed [44:0] ang;
      logic [63:0]        tot;
      logic [8:0]         u;
      logic [13:0]        mag;
      logic signed [31:0] prod;
      always_comb begin
         ang = $signed({7'd0, mul_ff[i], 8'd0}) - 45'(tq9_ff[i])
               + $signed({11'd0, ph9_ff[i], 18'd0});
         tot = (64'(phi_ff[i]) << 22) + 64'(plo_ff[i]);
         u   = idx_ff[i][8] ? (9'd256 - 9'(idx_ff[i][7:0])) : 9'(idx_ff[i][7:0]);
         mag = u[8] ? QS_TOP : qs_table[u[7:0]];
         prod = $signed({1'b0, amp13_ff[i]}) * sin_ff[i];
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            mul_ff[i]   <= 30'(front_ff[S_SQ_LAST][i].root) * 30'(front_ff[S_SQ_LAST][i].freq);
            ph9_ff[i]   <= front_ff[S_SQ_LAST][i].phase;
            tq9_ff[i]   <= front_ff[S_SQ_LAST][i].tq;
            amp9_ff[i]  <= front_ff[S_SQ_LAST][i].amp;
            ang_ff[i]   <= ang;
            amp10_ff[i] <= amp9_ff[i];
            phi_ff[i]   <= $signed(ang_ff[i][44:22])
                           * $signed({1'b0, rwpr_pkg::ANGLE_TO_INDEX});
            plo_ff[i]   <= 54'(ang_ff[i][21:0]) * 54'(rwpr_pkg::ANGLE_TO_INDEX);
            amp11_ff[i] <= amp10_ff[i];
            idx_ff[i]   <= tot[63:54];
            amp12_ff[i] <= amp11_ff[i];
            sin_ff[i]   <= idx_ff[i][9] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
            amp13_ff[i] <= amp12_ff[i];
            tree_ff[0][i] <= SUMW'(prod);
         end
      end
   end

   for (genvar j = SOURCES; j < NP; j++) begin : g_pad
      always_ff @(posedge clock) begin
         if (adv) begin
            tree_ff[0][j] <= '0;
         end
      end
   end

   // registered sum tree
   for (genvar l = 1; l <= LV; l++) begin : g_tree
      for (genvar j = 0; j < (NP >> l); j++) begin : g_node
         always_ff @(posedge clock) begin
            if (adv) begin
               tree_ff[l][j] <= tree_ff[l-1][2*j] + tree_ff[l-1][2*j+1];
            end
         end
      end
   end

   // palette position: clamp, scale, divide
   logic signed [SUMW:0] shifted;
   logic [NW-1:0]        brem_nx [1:QB];
   logic [QB-1:0]        bq_nx   [1:QB];
   logic [RW-1:0]        wrem_nx [1:8];
   logic [7:0]           wq_nx   [1:8];

   assign shifted = (SUMW + 1)'(tree_ff[LV][0]) + OFFSET;

   for (genvar j = 1; j <= QB; j++) begin : g_bdiv
      localparam logic [NW-1:0] DSH = NW'(DEN) << (QB - j);
      always_comb begin
         brem_nx[j] = brem_ff[j-1];
         bq_nx[j]   = bq_ff[j-1];
         if (brem_ff[j-1] >= DSH) begin
            brem_nx[j]       = brem_ff[j-1] - DSH;
            bq_nx[j][QB - j] = 1'b1;
         end
      end
   end

   for (genvar j = 1; j <= 8; j++) begin : g_wdiv
      localparam logic [RW-1:0] WSH = RW'(DEN) << (8 - j);
      always_comb begin
         wrem_nx[j] = wrem_ff[j-1];
         wq_nx[j]   = wq_ff[j-1];
         if (wrem_ff[j-1] >= WSH) begin
            wrem_nx[j]      = wrem_ff[j-1] - WSH;
            wq_nx[j][8 - j] = 1'b1;
         end
      end
   end

   logic [QB-1:0]  base_adj;
   logic [7:0]     wgt_adj;
   logic [QB-1:0]  next_adj;

   always_comb begin
      base_adj = wbase_ff[8];
      wgt_adj  = wq_ff[8];
      if (wbase_ff[8] >= pm1) begin
         base_adj = pm1;
         wgt_adj  = 8'd0;
      end
      next_adj = ((PSW'(base_adj) + PSW'(1)) < psz) ? QB'(PSW'(base_adj) + PSW'(1)) : base_adj;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (shifted <= 0) begin
            pos_ff <= '0;
         end else if (shifted >= (SUMW + 1)'(DEN)) begin
            pos_ff <= DEN;
         end else begin
            pos_ff <= PW'(shifted);
         end
         brem_ff[0] <= NW'(pos_ff) * NW'(pm1);
         bq_ff[0]   <= '0;
         for (int j = 1; j <= QB; j++) begin
            brem_ff[j] <= brem_nx[j];
            bq_ff[j]   <= bq_nx[j];
         end
         wrem_ff[0]  <= (RW'(brem_ff[QB]) << 8) - RW'(brem_ff[QB]);
         wq_ff[0]    <= '0;
         wbase_ff[0] <= bq_ff[QB];
         for (int j = 1; j <= 8; j++) begin
            wrem_ff[j]  <= wrem_nx[j];
            wq_ff[j]    <= wq_nx[j];
            wbase_ff[j] <= wbase_ff[j-1];
         end
         addr_a_ff <= base_adj;
         addr_b_ff <= next_adj;
         wgt_a_ff  <= wgt_adj;
         wgt_b_ff  <= wgt_a_ff;
      end
   end

   // palette; loads are applied where renders read
   assign ram_we = adv && ctl_ff[S_ADR].valid && ctl_ff[S_ADR].palw
                   && (ctl_ff[S_ADR].slot < PALETTE_DEPTH);

   rwpr_ram #(
      .WIDTH (24),
      .DEPTH (PALETTE_DEPTH)
   ) u_palette (
      .clock     (clock),
      .wr_en     (ram_we),
      .wr_addr   (QB'(ctl_ff[S_ADR].slot)),
      .wr_data   (ctl_ff[S_ADR].color),
      .rd_en     (adv),
      .rd_addr_a (addr_a_ff),
      .rd_addr_b (addr_b_ff),
      .rd_data_a (ram_rd_a),
      .rd_data_b (ram_rd_b)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= ctl_ff[NST].valid && ctl_ff[NST].render;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff.led_index <= ctl_ff[NST].led;
         rsp_data_ff.in_range  <= ctl_ff[NST].inr;
         if (psz == '0) begin
            rsp_data_ff.red   <= 8'd0;
            rsp_data_ff.green <= 8'd0;
            rsp_data_ff.blue  <= 8'd0;
         end else begin
            rsp_data_ff.red   <= blend(ram_rd_a[23:16], ram_rd_b[23:16], wgt_b_ff);
            rsp_data_ff.green <= blend(ram_rd_a[15:8], ram_rd_b[15:8], wgt_b_ff);
            rsp_data_ff.blue  <= blend(ram_rd_a[7:0], ram_rd_b[7:0], wgt_b_ff);
         end
      end
   end

endmodule
